/* rtl/fpt_pkg.sv */
// shared types for the fermat primality test block
package fpt_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_EXP,
    ST_MUL,
    ST_SQR,
    ST_FINISH
  } fpt_state_t;

  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned OUT_DATA_W = 8;
  localparam int unsigned FIELD_W    = 32;

endpackage

/* rtl/fermat_primality_test.sv */
// fermat primality test: one trial per input transfer, verdict on the last trial
//
// Each input transfer is one trial of a candidate n against a base. The base is first
// reduced mod n by a restoring remainder, one bit per cycle, with W = min(WIDTH, 32).
// Then base^(n-1) mod n is built by square-and-multiply over the bits of n-1; every
// modular product runs through one shared shift-and-add step unit over W multiplier bits.
// A candidate below two fails at once, and a base that reduces to zero fails after the
// reduction. The block takes no new transfer while a trial runs. On a trial marked by
// in_tlast, one result transfer carries whether every trial since the previous verdict
// gave one; a waiting result is held in the output register while the next trial is
// accepted and worked on.
module fermat_primality_test
  import fpt_pkg::*;
#(
  parameter int unsigned WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // candidate [31:0], base [63:32]
  input  logic                  in_tlast,   // last_trial
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // probably_prime [0], zero fill [7:1]
);

  localparam int unsigned DW = (WIDTH < FIELD_W) ? WIDTH : FIELD_W;
  localparam int unsigned CW = $clog2(DW);
  localparam logic [CW-1:0] CNT_LAST = CW'(DW - 1);

  fpt_state_t state_r, state_nxt;

  logic [DW-1:0] n_r, n_nxt;
  logic [DW-1:0] q_r, q_nxt;
  logic [DW-1:0] r_r, r_nxt;
  logic [DW-1:0] e_r, e_nxt;
  logic [DW-1:0] y_r, y_nxt;
  logic [DW-1:0] z_r, z_nxt;
  logic [DW-1:0] ma_r, ma_nxt;
  logic [DW-1:0] mb_r, mb_nxt;
  logic [DW-1:0] acc_r, acc_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          last_r, last_nxt;
  logic          ok_r, ok_nxt;
  logic          all_passed_r, all_passed_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          prime_r, prime_nxt;

  logic [DW-1:0] cand_in;
  logic [DW-1:0] base_in;
  logic [DW:0]   rem_ext;
  logic [DW-1:0] acc_room;
  logic [DW-1:0] acc_sum;
  logic [DW-1:0] dbl_room;
  logic [DW-1:0] dbl_sum;
  logic [DW-1:0] acc_step;
  logic          verdict;

  assign cand_in = in_tdata[DW-1:0];
  assign base_in = in_tdata[FIELD_W+DW-1:FIELD_W];

  // shared modular step unit: acc + ma and ma + ma, both mod n
  assign acc_room = n_r - ma_r;
  assign acc_sum  = (acc_r >= acc_room) ? (acc_r - acc_room) : (acc_r + ma_r);
  assign dbl_room = n_r - ma_r;
  assign dbl_sum  = (ma_r >= dbl_room) ? (ma_r - dbl_room) : (ma_r + ma_r);
  assign acc_step = mb_r[0] ? acc_sum : acc_r;

  assign rem_ext = {r_r, q_r[DW-1]};
  assign verdict = all_passed_r & ok_r;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-1){1'b0}}, prime_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      all_passed_r <= 1'b1;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      all_passed_r <= all_passed_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r     <= n_nxt;
    q_r     <= q_nxt;
    r_r     <= r_nxt;
    e_r     <= e_nxt;
    y_r     <= y_nxt;
    z_r     <= z_nxt;
    ma_r    <= ma_nxt;
    mb_r    <= mb_nxt;
    acc_r   <= acc_nxt;
    cnt_r   <= cnt_nxt;
    last_r  <= last_nxt;
    ok_r    <= ok_nxt;
    prime_r <= prime_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    n_nxt          = n_r;
    q_nxt          = q_r;
    r_nxt          = r_r;
    e_nxt          = e_r;
    y_nxt          = y_r;
    z_nxt          = z_r;
    ma_nxt         = ma_r;
    mb_nxt         = mb_r;
    acc_nxt        = acc_r;
    cnt_nxt        = cnt_r;
    last_nxt       = last_r;
    ok_nxt         = ok_r;
    all_passed_nxt = all_passed_r;
    out_valid_nxt  = out_valid_r;
    prime_nxt      = prime_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          n_nxt    = cand_in;
          q_nxt    = base_in;
          r_nxt    = '0;
          cnt_nxt  = '0;
          last_nxt = in_tlast;
          if (cand_in < DW'(2)) begin
            ok_nxt    = 1'b0;
            state_nxt = ST_FINISH;
          end else begin
            state_nxt = ST_REDUCE;
          end
        end
      end
      ST_REDUCE: begin
        // restoring remainder, one base bit per cycle
        if (rem_ext >= {1'b0, n_r}) begin
          r_nxt = DW'(rem_ext - {1'b0, n_r});
        end else begin
          r_nxt = rem_ext[DW-1:0];
        end
        q_nxt   = q_r << 1;
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CNT_LAST) begin
          z_nxt = r_nxt;
          e_nxt = n_r - DW'(1);
          y_nxt = DW'(1);
          if (r_nxt == '0) begin
            ok_nxt    = 1'b0;
            state_nxt = ST_FINISH;
          end else begin
            state_nxt = ST_EXP;
          end
        end
      end
      ST_EXP: begin
        acc_nxt = '0;
        cnt_nxt = '0;
        if (e_r == '0) begin
          ok_nxt    = (y_r == DW'(1));
          state_nxt = ST_FINISH;
        end else if (e_r[0]) begin
          ma_nxt    = y_r;
          mb_nxt    = z_r;
          state_nxt = ST_MUL;
        end else begin
          ma_nxt    = z_r;
          mb_nxt    = z_r;
          state_nxt = ST_SQR;
        end
      end
      ST_MUL: begin
        acc_nxt = acc_step;
        ma_nxt  = dbl_sum;
        mb_nxt  = mb_r >> 1;
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CNT_LAST) begin
          y_nxt     = acc_step;
          ma_nxt    = z_r;
          mb_nxt    = z_r;
          acc_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_SQR;
        end
      end
      ST_SQR: begin
        acc_nxt = acc_step;
        ma_nxt  = dbl_sum;
        mb_nxt  = mb_r >> 1;
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CNT_LAST) begin
          z_nxt     = acc_step;
          e_nxt     = e_r >> 1;
          state_nxt = ST_EXP;
        end
      end
      ST_FINISH: begin
        if (!last_r) begin
          all_passed_nxt = verdict;
          state_nxt      = ST_IDLE;
        end else if (!out_valid_r || out_tready) begin
          prime_nxt      = verdict;
          out_valid_nxt  = 1'b1;
          all_passed_nxt = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // operands of the step unit stay reduced below the modulus
  a_step_operands: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL || state_r == ST_SQR) |-> (acc_r < n_r && ma_r < n_r))
    else $error("modular step operand not reduced");

  // exponent loop only runs with reduced residues and a valid modulus
  a_exp_state: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXP) |-> (z_r < n_r && y_r < n_r && n_r >= DW'(2)))
    else $error("exponent loop entered with bad residues");

  // an accepted trial starts the reduction or fails at once
  a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ST_REDUCE || state_r == ST_FINISH))
    else $error("accepted trial did not start");

  // a verdict is raised only from the finish step of a last trial
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FINISH && last_r))
    else $error("result raised outside last trial");

  // a verdict clears the running pass flag
  a_flag_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && last_r && (!out_valid_r || out_tready)) |=> all_passed_r)
    else $error("pass flag not cleared after verdict");

endmodule

/* tb/sv/tb_fermat_primality_test.sv */
// testbench for the fermat primality test block: queued trials, predicted verdicts, checked
module tb_fermat_primality_test;
  import fpt_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int TRIAL_TARGET   = 280;
  localparam int DRAIN_CYCLES   = 2300;

  typedef struct packed {
    logic [31:0] cand;
    logic [31:0] base;
    logic        last;
  } trial_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  trial_t trial_q[$];
  bit     verdict_q[$];
  bit     all_pass_flag = 1'b1;
  int     total_trials = 0;
  int     sent_cnt = 0;
  int     verdict_cnt = 0;
  int     prime_cnt = 0;
  int     errors = 0;
  int     in_gap = 0;
  int     out_stall = 0;
  int     quiet = 0;
  wire    idle_en = (sent_cnt < total_trials - 40) && ((sent_cnt / 32) % 3 != 2);

  fermat_primality_test dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #10 clk = ~clk;

  function automatic bit fermat_pass(input logic [31:0] n, input logic [31:0] b);
    logic [63:0] m, z, y, e;
    if (n < 2) return 1'b0;
    m = {32'd0, n};
    z = {32'd0, b} % m;
    if (z == 0) return 1'b0;
    e = m - 1;
    y = 1;
    while (e != 0) begin
      if (e[0]) y = (y * z) % m;
      z = (z * z) % m;
      e = e >> 1;
    end
    return y == 1;
  endfunction

  function automatic logic [31:0] pick_candidate();
    logic [31:0] c;
    int unsigned d;
    bit isp;
    logic [31:0] big_primes[6] = '{32'd4294967291, 32'd4294967279, 32'd2147483647,
                                   32'd1000000007, 32'd998244353, 32'd65537};
    logic [31:0] carmichael[8] = '{32'd561, 32'd1105, 32'd1729, 32'd2465, 32'd8911,
                                   32'd41041, 32'd825265, 32'd3215031751};
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        c = $urandom_range(3, 65000) | 32'd1;
        do begin
          isp = 1'b1;
          for (d = 3; d * d <= c; d += 2)
            if (c % d == 0) isp = 1'b0;
          if (!isp) c += 2;
        end while (!isp);
      end
      3: c = big_primes[$urandom_range(0, 5)];
      4: c = carmichael[$urandom_range(0, 7)];
      5, 6: c = $urandom_range(2, 65535);
      default: begin
        c = $urandom;
        if (c < 2) c = 2;
      end
    endcase
    return c;
  endfunction

  function automatic logic [31:0] pick_base(input logic [31:0] c);
    case ($urandom_range(0, 15))
      0: return 32'd0;
      1: return c * $urandom_range(1, 32'hFFFFFFFF / c);
      2: return 32'd1;
      3: return c - 1;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_trial(input logic [31:0] c, input logic [31:0] b, input logic l);
    trial_t t;
    t.cand = c;
    t.base = b;
    t.last = l;
    trial_q.push_back(t);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
    errors++;
  endtask

  // driver: presents queued trials, predicts the verdict on each last-trial transfer
  always @(posedge clk) begin
    trial_t t;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap    <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        if (!fermat_pass(in_tdata[31:0], in_tdata[63:32])) all_pass_flag = 1'b0;
        if (in_tlast) begin
          verdict_q.push_back(all_pass_flag);
          all_pass_flag = 1'b1;
        end
        sent_cnt++;
      end
      if (!in_tvalid || in_tready) begin
        if (in_gap != 0) begin
          in_gap    <= in_gap - 1;
          in_tvalid <= 1'b0;
        end else if (trial_q.size() != 0) begin
          t = trial_q.pop_front();
          in_tdata  <= {t.base, t.cand};
          in_tlast  <= t.last;
          in_tvalid <= 1'b1;
          if (idle_en && $urandom_range(0, 4) == 0) in_gap <= $urandom_range(1, 7);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result transfer against the oldest predicted verdict
  always @(posedge clk) begin
    bit want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_stall  <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (verdict_q.size() == 0) begin
          report_mismatch("unexpected result, probably_prime", out_tdata[0], -1);
        end else begin
          want = verdict_q.pop_front();
          if (out_tdata[0] !== want) report_mismatch("probably_prime", out_tdata[0], want);
          verdict_cnt++;
          if (want) prime_cnt++;
        end
      end
      if (out_stall != 0) begin
        out_stall  <= out_stall - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (idle_en && $urandom_range(0, 4) == 0) out_stall <= $urandom_range(1, 7);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("watchdog expired after %0d quiet cycles", quiet);
      $display("FAIL fermat_primality_test");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    logic [31:0] c;
    int n_tr;
    int groups;
    // directed: field extremes and the corner candidates and bases
    add_trial(32'd2, 32'd3, 1'b1);
    add_trial(32'd2, 32'd4, 1'b1);
    add_trial(32'd0, 32'd5, 1'b1);
    add_trial(32'd1, 32'd5, 1'b1);
    add_trial(32'd7, 32'd0, 1'b1);
    add_trial(32'd7, 32'd14, 1'b1);
    add_trial(32'd4294967291, 32'hFFFFFFFF, 1'b1);
    add_trial(32'hFFFFFFFF, 32'd2, 1'b1);
    add_trial(32'd65537, 32'd3, 1'b0);
    add_trial(32'd65537, 32'd12345, 1'b0);
    add_trial(32'd65537, 32'hFFFFFFFF, 1'b1);
    add_trial(32'd561, 32'd2, 1'b0);
    add_trial(32'd561, 32'd3, 1'b0);
    add_trial(32'd561, 32'd5, 1'b1);
    add_trial(32'd341, 32'd2, 1'b1);
    add_trial(32'd341, 32'd3, 1'b1);
    add_trial(32'd3, 32'd1, 1'b1);
    add_trial(32'd3, 32'd2, 1'b1);
    add_trial(32'h80000000, 32'h80000001, 1'b1);
    add_trial(32'd2147483647, 32'h7FFFFFFF, 1'b1);
    add_trial(32'd0, 32'd0, 1'b0);
    add_trial(32'd13, 32'd6, 1'b1);
    groups = 0;
    // random: runs of trials on one candidate, a few with noisy candidates mixed in
    while (trial_q.size() < TRIAL_TARGET) begin
      c = pick_candidate();
      n_tr = $urandom_range(1, 4);
      for (int i = 0; i < n_tr; i++) begin
        if ($urandom_range(0, 19) == 0) add_trial($urandom_range(0, 1), $urandom, 1'b0);
        add_trial(c, pick_base(c), i == n_tr - 1);
      end
      groups++;
    end
    total_trials = trial_q.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (trial_q.size() != 0 || in_tvalid || verdict_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("ran %0d trials (%0d random candidate runs) and checked %0d verdicts",
             sent_cnt, groups, verdict_cnt);
    $display("%0d verdicts said probably prime, %0d mismatches", prime_cnt, errors);
    if (errors == 0) begin
      $display("PASS fermat_primality_test");
    end else begin
      $display("FAIL fermat_primality_test");
    end
    $finish;
  end

endmodule
